>>> rtl/core/bred_pkg.sv
// Package with the sizes, decode addresses and bank lookup table of the banked RAM decoder.
package bred_pkg;

   // Number of RAM banks and the size of one bank.
   localparam int NUM_BANKS = 16;
   localparam int BANK_BYTES = 32768;
   localparam int OFFSET_W = 15;
   localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
   localparam int RAM_DEPTH = NUM_BANKS * BANK_BYTES;
   localparam int RAM_ADDR_W = BANK_W + OFFSET_W;

   // Bus decode masks and base addresses.
   localparam logic [15:0] SPI_MASK = 16'hFFFC;
   localparam logic [15:0] SPI_BASE = 16'hFF6C;
   localparam logic [15:0] CTL_MASK = 16'hFFFE;
   localparam logic [15:0] DISABLE_BASE = 16'hFFDE;
   localparam logic [15:0] MAP_BASE = 16'hFFBE;
   localparam logic [15:0] WINDOW_LOW = 16'h8000;
   localparam logic [15:0] WINDOW_HIGH = 16'hFF00;
   localparam logic [15:0] OFFSET_MASK = 16'h7FFF;

   // Access kinds carried on the command bit.
   localparam logic CMD_READ = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef logic [BANK_W-1:0] bank_type;

   // Builds the table that maps a data byte to its bank number.
   function automatic bank_type [255:0] make_bank_table();
      bank_type [255:0] table_v;
      for (int i = 0; i < 256; i++) begin
         table_v[i] = bank_type'(i % NUM_BANKS);
      end
      return table_v;
   endfunction

   localparam bank_type [255:0] BANK_TABLE = make_bank_table();

endpackage

>>> rtl/core/banked_ram_expansion_decoder.sv
// Top level of the banked RAM expansion decoder: bus decode, bank registers and banked RAM.

// Each request transfer is one bus access and yields one response transfer. The block
// takes one access per cycle while responses are not stalled: an access enters the
// decode stage, which updates the control flags or issues its single RAM read or write,
// and its response appears in the next cycle from the output register, which holds while
// the response is stalled. The RAM is a single-port synchronous memory with a registered
// read. After reset the block clears the whole RAM, one byte a cycle, NUM_BANKS * 32768
// bytes (524288 at the default 16 banks); req_ready stays low until the clear is done.
// Bank numbers are taken from the write data modulo NUM_BANKS.
module banked_ram_expansion_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_out,
   output logic        rsp_mem_claimed,
   output logic        rsp_spi_hit
);

   localparam logic [bred_pkg::RAM_ADDR_W-1:0] CLEAR_LAST =
      bred_pkg::RAM_ADDR_W'(bred_pkg::RAM_DEPTH - 1);

   // Control state.
   logic                              clear_ff, clear_in;
   logic [bred_pkg::RAM_ADDR_W-1:0]   clear_cnt_ff, clear_cnt_in;
   logic                              map_enable_ff, map_enable_in;
   logic                              type_disable_ff, type_disable_in;
   bred_pkg::bank_type                bank_select_ff, bank_select_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Response payload.
   logic [7:0]                        pass_data_ff;
   logic                              use_ram_ff;
   logic                              claimed_ff;
   logic                              spi_ff;
   logic [7:0]                        ram_q_ff;

   // Memory.
   logic [7:0]                        bank_ram [bred_pkg::RAM_DEPTH];
   logic                              ram_we;
   logic                              ram_re;
   logic [bred_pkg::RAM_ADDR_W-1:0]   ram_addr;
   logic [7:0]                        ram_wdata;

   // Decode signals.
   logic accept;
   logic spi_hit;
   logic window;
   logic ctl_disable;
   logic ctl_map;
   logic read_hit;
   logic write_hit;
   logic claimed;
   logic [bred_pkg::RAM_ADDR_W-1:0] access_addr;

   // A new access is taken when the clear pass is over and the output register frees up.
   assign req_ready = !clear_ff && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;

   // Address decode of the incoming access against the current control flags.
   always_comb begin
      spi_hit = (req_address & bred_pkg::SPI_MASK) == bred_pkg::SPI_BASE;
      window = (req_address >= bred_pkg::WINDOW_LOW) && (req_address < bred_pkg::WINDOW_HIGH)
               && !type_disable_ff && map_enable_ff;
      ctl_disable = (req_cmd == bred_pkg::CMD_WRITE)
                    && ((req_address & bred_pkg::CTL_MASK) == bred_pkg::DISABLE_BASE);
      ctl_map = (req_cmd == bred_pkg::CMD_WRITE) && !ctl_disable
                && ((req_address & bred_pkg::CTL_MASK) == bred_pkg::MAP_BASE);
      read_hit = (req_cmd == bred_pkg::CMD_READ) && !spi_hit && window;
      write_hit = (req_cmd == bred_pkg::CMD_WRITE) && !ctl_disable && !ctl_map && window;
      claimed = read_hit || ctl_map || write_hit;
      access_addr = {bank_select_ff,
                     req_address[bred_pkg::OFFSET_W-1:0] &
                     bred_pkg::OFFSET_MASK[bred_pkg::OFFSET_W-1:0]};
   end

   // Control register updates and clear pass sequencing.
   always_comb begin
      map_enable_in = map_enable_ff;
      type_disable_in = type_disable_ff;
      bank_select_in = bank_select_ff;
      clear_in = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == CLEAR_LAST) begin
            clear_in = 1'b0;
         end
      end
      if (accept && ctl_disable) begin
         type_disable_in = req_address[0];
      end
      if (accept && ctl_map) begin
         map_enable_in = req_address[0];
         bank_select_in = bred_pkg::BANK_TABLE[req_data_in];
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // RAM port: the clear pass owns it until done, then the accepted access does.
   always_comb begin
      ram_we = clear_ff || (accept && write_hit);
      ram_re = accept && read_hit;
      ram_addr = clear_ff ? clear_cnt_ff : access_addr;
      ram_wdata = clear_ff ? 8'h00 : req_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clear_cnt_ff <= '0;
         map_enable_ff <= 1'b0;
         type_disable_ff <= 1'b0;
         bank_select_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         map_enable_ff <= map_enable_in;
         type_disable_ff <= type_disable_in;
         bank_select_ff <= bank_select_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload loads with each accepted access.
   always_ff @(posedge clock) begin
      if (accept) begin
         pass_data_ff <= req_data_in;
         use_ram_ff <= read_hit;
         claimed_ff <= claimed;
         spi_ff <= spi_hit;
      end
   end

   // Banked RAM with a registered read.
   always_ff @(posedge clock) begin
      if (ram_we) begin
         bank_ram[ram_addr] <= ram_wdata;
      end
      if (ram_re) begin
         ram_q_ff <= bank_ram[ram_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data_out = use_ram_ff ? ram_q_ff : pass_data_ff;
   assign rsp_mem_claimed = claimed_ff;
   assign rsp_spi_hit = spi_ff;

endmodule
